@@ hdl/sliding_window_lane_search_defines.svh @@
// Assertion macros used by the lane search top level.
`ifndef SLIDING_WINDOW_LANE_SEARCH_DEFINES_SVH
`define SLIDING_WINDOW_LANE_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SWL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lane search: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define SWL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lane search: next-cycle check failed");

`endif

@@ hdl/swl_pkg.sv @@
// Types, constants and helpers for the sliding window lane search.
`default_nettype none

package swl_pkg;

    // Field widths
    localparam int DIM_W      = 12;
    localparam int CFG_DIM_W  = 13;
    localparam int CFG_WIN_W  = 7;
    localparam int HALF_W     = 11;
    localparam int WIN_IDX_W  = 6;
    localparam int COUNT_W    = 24;
    localparam int SUM_W      = 36;
    localparam int QUO_W      = 13;
    localparam int BOUND_W    = 19;
    localparam int COVER_W    = 20;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Limits and register reset values
    localparam logic [CFG_DIM_W-1:0] MAX_DIM        = 13'd4096;
    localparam logic [CFG_WIN_W-1:0] MAX_WINDOWS    = 7'd64;
    localparam int                   LANES_DEFAULT  = 2;
    localparam logic [CFG_DIM_W-1:0] RST_IMG_WIDTH  = 13'd1280;
    localparam logic [CFG_DIM_W-1:0] RST_IMG_HEIGHT = 13'd720;
    localparam logic [CFG_WIN_W-1:0] RST_WIN_COUNT  = 7'd9;
    localparam logic [HALF_W-1:0]    RST_HALF_WIDTH = 11'd100;
    localparam logic [COUNT_W-1:0]   COUNT_MAX      = '1;

    // Shared divider: one quotient bit per cycle over the full dividend
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_PIXEL = 1'b1
    } swl_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_WINDOW_COUNT = 2'd2,
        REG_HALF_WIDTH   = 2'd3
    } swl_reg_t;

    typedef struct packed {
        swl_cmd_t         cmd;
        logic [DIM_W-1:0] start_left;
        logic [DIM_W-1:0] start_right;
        logic             pixel_on;
    } swl_in_t;

    typedef struct packed {
        logic                 lane;
        logic [WIN_IDX_W-1:0] window_index;
        logic [DIM_W-1:0]     window_left;
        logic [DIM_W-1:0]     window_top;
        logic [COUNT_W-1:0]   pixel_count;
        logic [DIM_W-1:0]     next_center;
        logic                 moved;
        logic                 last;
    } swl_out_t;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } swl_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } swl_div_rsp_t;

    typedef struct packed {
        logic             start;
        logic             hit_en;
        logic             retire;
        logic [DIM_W-1:0] column;
        logic [DIM_W-1:0] next_center;
    } swl_lane_ctl_t;

    typedef struct packed {
        logic [DIM_W-1:0]   lo;
        logic [DIM_W-1:0]   center;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
    } swl_lane_stat_t;

    // Image dimension as used: 1 .. MAX_DIM
    function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        logic [CFG_DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = CFG_DIM_W'(1);
        else if (v > MAX_DIM)
            r = MAX_DIM;
        return r;
    endfunction

    // Window count as used: 1 .. MAX_WINDOWS
    function automatic logic [CFG_WIN_W-1:0] clamp_windows(input logic [CFG_WIN_W-1:0] v);
        logic [CFG_WIN_W-1:0] r;
        r = v;
        if (v == '0)
            r = CFG_WIN_W'(1);
        else if (v > MAX_WINDOWS)
            r = MAX_WINDOWS;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/swl_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module swl_div
    import swl_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire swl_div_req_t req,
    output      swl_div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     dvd_reg;
    logic [COUNT_W-1:0]   dvs_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [QUO_W-1:0]     quo_reg;

    logic [COUNT_W:0]     trial;
    logic [COUNT_W:0]     diff;
    logic                 ge;
    logic [COUNT_W-1:0]   rem_next;

    // One trial subtraction
    assign trial    = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign rem_next = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];

    // Iteration control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

@@ hdl/swl_lane.sv @@
// One lane: window bounds, pixel count and column sum, current center.
`default_nettype none

module swl_lane
    import swl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire swl_lane_ctl_t    ctl,
    input  wire logic [DIM_W-1:0] start_center,
    input  wire logic [CFG_DIM_W-1:0] width,
    input  wire logic [HALF_W-1:0] half_width,
    output      swl_lane_stat_t   stat
);

    logic [DIM_W-1:0]     center_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]     sum_reg;

    logic [DIM_W-1:0]     lo;
    logic [CFG_DIM_W-1:0] hi;
    logic                 hit;

    // Window bounds, left clamped at zero, right compared against the row width
    assign lo  = (center_reg >= {1'b0, half_width}) ? center_reg - {1'b0, half_width} : '0;
    assign hi  = {1'b0, center_reg} + {2'b00, half_width};
    assign hit = (ctl.column >= lo) && ({1'b0, ctl.column} < hi) && ({1'b0, ctl.column} < width);

    // Accumulators and center
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
        end
        else if (ctl.start)
        begin
            center_reg <= start_center;
            count_reg  <= '0;
            sum_reg    <= '0;
        end
        else if (ctl.retire)
        begin
            center_reg <= ctl.next_center;
            count_reg  <= '0;
            sum_reg    <= '0;
        end
        else if (ctl.hit_en && hit)
        begin
            if (count_reg != COUNT_MAX)
                count_reg <= count_reg + 1'b1;
            sum_reg <= sum_reg + SUM_W'(ctl.column);
        end
    end

    assign stat.lo     = lo;
    assign stat.center = center_reg;
    assign stat.count  = count_reg;
    assign stat.sum    = sum_reg;

endmodule

`default_nettype wire

@@ hdl/sliding_window_lane_search.sv @@
// Top level of the sliding window lane search with its sequencer.
//
//  channel | signals                         | direction | carries
//  --------+---------------------------------+-----------+-------------------------------
//  item    | item_valid item_ready item      | into      | start command or one pixel
//  result  | result_valid result_ready result| out of    | one window result per lane
//  cfg     | cfg_valid cfg_ready cfg_index   | into      | register write, always ready
//          | cfg_data                        |           |
//
// A pixel that does not close a window leaves the item channel ready.
// A pixel closing a window holds off the item channel while each lane in turn goes through
// launch, the shared divider working out its mean, and hand-over to the result stage.
// A start transfer holds off the item channel while the same divider works out the window height.
// The result stage stalls the sequencer only when its register is still full.
// Reset clears all control state at once; there is no clearing pass.
`default_nettype none

`include "sliding_window_lane_search_defines.svh"

module sliding_window_lane_search
    import swl_pkg::*;
#(
    parameter int LANES = LANES_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output      logic                  item_ready,
    input  wire swl_in_t               item,
    output      logic                  result_valid,
    input  wire logic                  result_ready,
    output      swl_out_t              result,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LANE_IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [LANE_IDX_W-1:0] LAST_LANE = LANE_IDX_W'(LANES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_WR,
        ST_LAUNCH,
        ST_DIV_MEAN,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [LANE_IDX_W-1:0]   lane_idx_reg;
    logic                    result_valid_reg;
    swl_out_t                result_reg;

    logic [CFG_DIM_W-1:0]    img_width_reg;
    logic [CFG_DIM_W-1:0]    img_height_reg;
    logic [CFG_WIN_W-1:0]    win_count_reg;
    logic [HALF_W-1:0]       half_width_reg;

    logic [DIM_W-1:0]        row_reg;
    logic [DIM_W-1:0]        col_reg;
    logic [WIN_IDX_W-1:0]    win_num_reg;
    logic [QUO_W-1:0]        win_rows_reg;
    logic [BOUND_W-1:0]      boundary_reg;
    logic                    active_reg;
    logic [WIN_IDX_W-1:0]    res_win_reg;
    logic [DIM_W-1:0]        res_top_reg;
    logic [QUO_W-1:0]        mean_reg;

    logic [CFG_DIM_W-1:0]    w_c;
    logic [CFG_DIM_W-1:0]    h_c;
    logic [CFG_WIN_W-1:0]    n_c;
    logic [COVER_W-1:0]      covered;
    logic [CFG_DIM_W-1:0]    col_next;
    logic [CFG_DIM_W-1:0]    rows_done;
    logic                    col_last;
    logic                    win_end;
    logic                    wn_step;
    logic [DIM_W-1:0]        top;
    logic                    item_fire;
    logic                    start_fire;
    logic                    pix_fire;
    logic                    emit_load;
    logic                    moved;
    swl_out_t                emit_data;
    swl_lane_stat_t          sel;
    swl_div_req_t            div_req;
    swl_div_rsp_t            div_rsp;
    swl_lane_ctl_t           lane_ctl  [LANES];
    swl_lane_stat_t          lane_stat [LANES];

    // Handshakes
    assign item_ready   = (state_reg == ST_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign start_fire   = item_fire && (item.cmd == CMD_START);
    assign pix_fire     = item_fire && (item.cmd == CMD_PIXEL) && active_reg;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= RST_IMG_WIDTH;
            img_height_reg <= RST_IMG_HEIGHT;
            win_count_reg  <= RST_WIN_COUNT;
            half_width_reg <= RST_HALF_WIDTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (swl_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  img_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: img_height_reg <= cfg_data;
                REG_WINDOW_COUNT: win_count_reg  <= cfg_data[CFG_WIN_W-1:0];
                REG_HALF_WIDTH:   half_width_reg <= cfg_data[HALF_W-1:0];
                default:          img_width_reg  <= img_width_reg;
            endcase
        end
    end

    // Live, clamped geometry
    assign w_c = clamp_dim(img_width_reg);
    assign h_c = clamp_dim(img_height_reg);
    assign n_c = clamp_windows(win_count_reg);

    // Row, column and window bookkeeping for the pixel being taken
    assign covered   = COVER_W'(n_c) * COVER_W'(win_rows_reg);
    assign col_next  = {1'b0, col_reg} + 1'b1;
    assign rows_done = {1'b0, row_reg} + 1'b1;
    assign col_last  = col_next >= w_c;
    assign win_end   = col_last && (win_rows_reg != '0) && (COVER_W'(rows_done) <= covered)
                       && (BOUND_W'(rows_done) == boundary_reg);
    assign wn_step   = ({1'b0, win_num_reg} + 1'b1) < n_c;
    assign top       = (boundary_reg >= BOUND_W'(h_c)) ? '0
                       : DIM_W'(h_c - boundary_reg[CFG_DIM_W-1:0]);

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            win_num_reg  <= '0;
            win_rows_reg <= '0;
            boundary_reg <= '0;
            active_reg   <= 1'b0;
            res_win_reg  <= '0;
            res_top_reg  <= '0;
            mean_reg     <= '0;
        end
        else
        begin
            if (start_fire)
            begin
                row_reg      <= '0;
                col_reg      <= '0;
                win_num_reg  <= '0;
                win_rows_reg <= '0;
                boundary_reg <= '0;
                active_reg   <= 1'b1;
            end
            else if (pix_fire)
            begin
                if (win_end)
                begin
                    res_win_reg <= win_num_reg;
                    res_top_reg <= top;
                    if (wn_step)
                    begin
                        win_num_reg  <= win_num_reg + 1'b1;
                        boundary_reg <= boundary_reg + BOUND_W'(win_rows_reg);
                    end
                end
                if (col_last)
                begin
                    col_reg <= '0;
                    if (rows_done >= h_c)
                        active_reg <= 1'b0;
                    else
                        row_reg <= rows_done[DIM_W-1:0];
                end
                else
                    col_reg <= col_next[DIM_W-1:0];
            end
            if ((state_reg == ST_DIV_WR) && div_rsp.done)
            begin
                win_rows_reg <= div_rsp.quotient;
                boundary_reg <= BOUND_W'(div_rsp.quotient);
            end
            if ((state_reg == ST_DIV_MEAN) && div_rsp.done)
                mean_reg <= div_rsp.quotient;
        end
    end

    // Lane units
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        assign lane_ctl[k].start       = start_fire;
        assign lane_ctl[k].hit_en      = pix_fire && item.pixel_on && (win_rows_reg != '0)
                                         && (COVER_W'(row_reg) < covered);
        assign lane_ctl[k].retire      = emit_load && (lane_idx_reg == LANE_IDX_W'(k));
        assign lane_ctl[k].column      = col_reg;
        assign lane_ctl[k].next_center = emit_data.next_center;

        swl_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (lane_ctl[k]),
            .start_center ((k == 0) ? item.start_left : item.start_right),
            .width        (w_c),
            .half_width   (half_width_reg),
            .stat         (lane_stat[k])
        );
    end

    assign sel = lane_stat[lane_idx_reg];

    // Shared divider: window height at start, lane mean at each window end
    assign div_req.start    = start_fire || (state_reg == ST_LAUNCH);
    assign div_req.dividend = (state_reg == ST_IDLE) ? SUM_W'(h_c) : sel.sum;
    assign div_req.divisor  = (state_reg == ST_IDLE) ? COUNT_W'(n_c) : sel.count;

    swl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Result for the selected lane
    assign moved     = (sel.count != '0) && (mean_reg != '0);
    assign emit_load = (state_reg == ST_EMIT) && (!result_valid_reg || result_ready);

    always_comb
    begin
        emit_data.lane         = 1'(lane_idx_reg);
        emit_data.window_index = res_win_reg;
        emit_data.window_left  = sel.lo;
        emit_data.window_top   = res_top_reg;
        emit_data.pixel_count  = sel.count;
        emit_data.next_center  = moved ? mean_reg[DIM_W-1:0] : sel.center;
        emit_data.moved        = moved;
        emit_data.last         = (lane_idx_reg == LAST_LANE);
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lane_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            // a new result takes the register as the old one leaves
            if (emit_load)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && result_ready)
                result_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start_fire)
                        state_reg <= ST_DIV_WR;
                    else if (pix_fire && win_end)
                    begin
                        state_reg    <= ST_LAUNCH;
                        lane_idx_reg <= '0;
                    end
                end
                ST_DIV_WR:
                begin
                    if (div_rsp.done)
                        state_reg <= ST_IDLE;
                end
                ST_LAUNCH:
                    state_reg <= ST_DIV_MEAN;
                ST_DIV_MEAN:
                begin
                    if (div_rsp.done)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        result_reg <= emit_data;
                        if (lane_idx_reg == LAST_LANE)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            lane_idx_reg <= LANE_IDX_W'(lane_idx_reg + 1'b1);
                            state_reg    <= ST_LAUNCH;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Checks
    `SWL_ASSERT_NOW(a_done_when_waiting, div_rsp.done, (state_reg == ST_DIV_WR) || (state_reg == ST_DIV_MEAN))
    `SWL_ASSERT_NOW(a_div_idle_in_idle, state_reg == ST_IDLE, !div_rsp.busy)
    `SWL_ASSERT_NEXT(a_window_end_launch, pix_fire && win_end, state_reg == ST_LAUNCH)
    `SWL_ASSERT_NOW(a_boundary_track, active_reg && (state_reg != ST_DIV_WR), COVER_W'(boundary_reg) == (COVER_W'(win_num_reg) + 20'd1) * COVER_W'(win_rows_reg))

endmodule

`default_nettype wire
